### design/fdtb_pkg.sv
// Package for the fragment depth test and blend block.
// Holds sizes, codes, the command and configuration structs and helpers.
// Used by every module of the block but the RAM; depends on nothing.
package fdtb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int DIM_W      = 9;
	localparam int DEPTH_W    = 18;
	localparam int CHAN_W     = 12;
	localparam int ALPHA_W    = 13;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int QUO_W      = DEPTH_W - 1;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 18'sd131071;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -18'sd131072;
	localparam logic [ALPHA_W-1:0]        ALPHA_ONE = 13'd4096;

	localparam logic [0:0] OP_FRAG  = 1'b0;
	localparam logic [0:0] OP_CLEAR = 1'b1;

	localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_DEPTH_FUNC   = 3'd2;
	localparam logic [2:0] CFG_DEPTH_WRITE  = 3'd3;
	localparam logic [2:0] CFG_BLEND_MODE   = 3'd4;

	localparam logic [2:0] DF_ALWAYS  = 3'd0;
	localparam logic [2:0] DF_LESS    = 3'd1;
	localparam logic [2:0] DF_LEQUAL  = 3'd2;
	localparam logic [2:0] DF_GREATER = 3'd3;
	localparam logic [2:0] DF_GEQUAL  = 3'd4;
	localparam logic [2:0] DF_EQUAL   = 3'd5;
	localparam logic [2:0] DF_NEQUAL  = 3'd6;

	localparam logic [1:0] BM_REPLACE = 2'd0;
	localparam logic [1:0] BM_ADD     = 2'd1;
	localparam logic [1:0] BM_ALPHA   = 2'd2;

	typedef enum logic [1:0] {
		K_FRAG   = 2'd0,
		K_REJECT = 2'd1,
		K_CLEAR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [ADDR_W-1:0]         addr;
		logic signed [DEPTH_W-1:0] depth;
		logic [CHAN_W-1:0]         r;
		logic [CHAN_W-1:0]         g;
		logic [CHAN_W-1:0]         b;
		logic [ALPHA_W-1:0]        a;
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [2:0]       depth_func;
		logic             depth_write;
		logic [1:0]       blend_mode;
	} cfg_t;

	function automatic logic depth_pass(input logic [2:0] func,
			input logic signed [DEPTH_W-1:0] stored, input logic signed [DEPTH_W-1:0] d);
		logic p;
		unique case (func)
			DF_ALWAYS:  p = 1'b1;
			DF_LESS:    p = d < stored;
			DF_LEQUAL:  p = d <= stored;
			DF_GREATER: p = d > stored;
			DF_GEQUAL:  p = d >= stored;
			DF_EQUAL:   p = d == stored;
			DF_NEQUAL:  p = d != stored;
			default:    p = 1'b0;
		endcase
		return p;
	endfunction

endpackage

### design/fragment_depth_test_and_blend.sv
// Top level of the fragment depth test and blend block.
// Holds the configuration registers and joins front, queue and back.
// Depends on fdtb_pkg, fdtb_front, fdtb_queue and fdtb_back.
//
// Requests enter on the s_ channel: s_tuser is the op (fragment or clear),
// s_tdata the pixel, depth terms and color. Every request gives one result on
// the m_ channel: m_tuser is the pass flag, m_tdata the color and depth now
// stored at the pixel, or zero outside the frame. Registers are to be written
// on the cfg channel while idle; the block does not enforce this. The front
// takes one request at a time; a fragment inside the frame with a nonzero w
// and no depth overflow goes through the bit-serial divider, others skip it;
// each enters the two-entry queue from a push state that waits while it is
// full. For a fragment the back reads the stores, tests, blends the three
// channels one at a time and writes; a clear writes width*height pixels, one
// pixel per cycle on the store write port. Reset clears control state and
// the registers to their defaults; the stores are not cleared and must be
// written by a clear first. When the receiver stalls, the result stays in
// the output register, the back part halts and the queue fills; then the
// front stops taking requests.
module fragment_depth_test_and_blend (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // pix_x, pix_y, frag_z, frag_w, frag_r, frag_g, frag_b, frag_a
	input  logic         s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [55:0]  m_tdata,  // out_r, out_g, out_b, out_depth
	output logic         m_tuser,  // passed
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [8:0]   cfg_data
);

	logic [fdtb_pkg::DIM_W-1:0] width_q;
	logic [fdtb_pkg::DIM_W-1:0] height_q;
	logic [2:0]                 func_q;
	logic                       dwrite_q;
	logic [1:0]                 bmode_q;
	fdtb_pkg::cfg_t             cfg;

	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	fdtb_pkg::cmd_t       push_cmd;
	fdtb_pkg::cmd_t       pop_cmd;
	logic [fdtb_pkg::CHAN_W-1:0] o_r;
	logic [fdtb_pkg::CHAN_W-1:0] o_g;
	logic [fdtb_pkg::CHAN_W-1:0] o_b;
	logic signed [fdtb_pkg::DEPTH_W-1:0] o_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'(fdtb_pkg::MAX_WIDTH);
			height_q <= 9'(fdtb_pkg::MAX_HEIGHT);
			func_q   <= fdtb_pkg::DF_LESS;
			dwrite_q <= 1'b1;
			bmode_q  <= fdtb_pkg::BM_REPLACE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fdtb_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				fdtb_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				fdtb_pkg::CFG_DEPTH_FUNC:   func_q   <= cfg_data[2:0];
				fdtb_pkg::CFG_DEPTH_WRITE:  dwrite_q <= cfg_data[0];
				fdtb_pkg::CFG_BLEND_MODE:   bmode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.width = width_q;
		if (width_q == '0) begin
			cfg.width = 9'd1;
		end else if (width_q > 9'(fdtb_pkg::MAX_WIDTH)) begin
			cfg.width = 9'(fdtb_pkg::MAX_WIDTH);
		end
		cfg.height = height_q;
		if (height_q == '0) begin
			cfg.height = 9'd1;
		end else if (height_q > 9'(fdtb_pkg::MAX_HEIGHT)) begin
			cfg.height = 9'(fdtb_pkg::MAX_HEIGHT);
		end
		cfg.depth_func  = func_q;
		cfg.depth_write = dwrite_q;
		cfg.blend_mode  = bmode_q;
	end

	fdtb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_x     (s_tdata[7:0]),
		.in_y     (s_tdata[15:8]),
		.in_z     (s_tdata[39:16]),
		.in_w     (s_tdata[63:40]),
		.in_r     (s_tdata[75:64]),
		.in_g     (s_tdata[87:76]),
		.in_b     (s_tdata[99:88]),
		.in_a     (s_tdata[112:100]),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	fdtb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (pop_cmd),
		.full   (full),
		.empty  (empty)
	);

	fdtb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.empty      (empty),
		.qcmd       (pop_cmd),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_passed (m_tuser),
		.out_r      (o_r),
		.out_g      (o_g),
		.out_b      (o_b),
		.out_depth  (o_d)
	);

	assign m_tdata = {2'b00, o_d, o_b, o_g, o_r};

endmodule

### design/fdtb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the color and depth stores; depends on nothing.
module fdtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/fdtb_front.sv
// Front part: accepts input items, classifies them and forms the depth.
// The depth z / w comes from a bit-serial divider; depends on fdtb_pkg.
module fdtb_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fdtb_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_op,
	input  logic [7:0]                in_x,
	input  logic [7:0]                in_y,
	input  logic signed [23:0]        in_z,
	input  logic signed [23:0]        in_w,
	input  logic [fdtb_pkg::CHAN_W-1:0]  in_r,
	input  logic [fdtb_pkg::CHAN_W-1:0]  in_g,
	input  logic [fdtb_pkg::CHAN_W-1:0]  in_b,
	input  logic [fdtb_pkg::ALPHA_W-1:0] in_a,
	output logic                      push,
	output fdtb_pkg::cmd_t            push_cmd,
	input  logic                      full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t            state_q;
	fdtb_pkg::cmd_t     cmd_q;
	logic [23:0]        rem_q;
	logic [23:0]        dvs_q;
	logic [fdtb_pkg::QUO_W-1:0] quo_q;
	logic [4:0]         cnt_q;
	logic               zb0_q;
	logic               neg_q;

	logic [23:0]        mag_z;
	logic [23:0]        mag_w;
	logic               ovf;
	logic               outside;
	logic [16:0]        index;
	logic signed [fdtb_pkg::DEPTH_W-1:0] clr_depth;
	logic [fdtb_pkg::ALPHA_W-1:0] a_clamp;
	logic [24:0]        trial;
	logic               take;
	logic [fdtb_pkg::QUO_W-1:0] quo_next;
	logic [fdtb_pkg::DEPTH_W-1:0] quo_ext;

	assign mag_z    = in_z[23] ? 24'(-in_z) : 24'(in_z);
	assign mag_w    = in_w[23] ? 24'(-in_w) : 24'(in_w);
	assign ovf      = {1'b0, mag_z} >= {mag_w, 1'b0};
	assign outside  = ({1'b0, in_x} >= cfg.width) || ({1'b0, in_y} >= cfg.height);
	assign index    = 17'(in_y * cfg.width) + 17'(in_x);
	assign a_clamp  = (in_a > fdtb_pkg::ALPHA_ONE) ? fdtb_pkg::ALPHA_ONE : in_a;
	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !full;
	assign push_cmd = cmd_q;

	always_comb begin
		if (in_z > 24'sd131071) begin
			clr_depth = fdtb_pkg::DEPTH_MAX;
		end else if (in_z < -24'sd131072) begin
			clr_depth = fdtb_pkg::DEPTH_MIN;
		end else begin
			clr_depth = in_z[fdtb_pkg::DEPTH_W-1:0];
		end
	end

	assign trial    = {rem_q, (cnt_q == 5'd0) ? zb0_q : 1'b0};
	assign take     = trial >= {1'b0, dvs_q};
	assign quo_next = {quo_q[fdtb_pkg::QUO_W-2:0], take};
	assign quo_ext  = {1'b0, quo_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						if (in_op == fdtb_pkg::OP_CLEAR || outside || in_w == 24'sd0 || ovf) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (cnt_q == 5'(fdtb_pkg::QUO_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			cmd_q.addr <= index[fdtb_pkg::ADDR_W-1:0];
			cmd_q.r    <= in_r;
			cmd_q.g    <= in_g;
			cmd_q.b    <= in_b;
			cmd_q.a    <= a_clamp;
			rem_q      <= {1'b0, mag_z[23:1]};
			dvs_q      <= mag_w;
			zb0_q      <= mag_z[0];
			neg_q      <= in_z[23] ^ in_w[23];
			quo_q      <= '0;
			cnt_q      <= '0;
			if (in_op == fdtb_pkg::OP_CLEAR) begin
				cmd_q.kind  <= fdtb_pkg::K_CLEAR;
				cmd_q.depth <= clr_depth;
			end else if (outside) begin
				cmd_q.kind  <= fdtb_pkg::K_REJECT;
				cmd_q.depth <= '0;
			end else begin
				cmd_q.kind <= fdtb_pkg::K_FRAG;
				if (in_w == 24'sd0) begin
					cmd_q.depth <= fdtb_pkg::DEPTH_MAX;
				end else if (ovf) begin
					cmd_q.depth <= (in_z[23] ^ in_w[23]) ? fdtb_pkg::DEPTH_MIN
						: fdtb_pkg::DEPTH_MAX;
				end else begin
					cmd_q.depth <= '0;
				end
			end
		end else if (state_q == F_DIV) begin
			rem_q <= take ? 24'(trial - {1'b0, dvs_q}) : trial[23:0];
			quo_q <= quo_next;
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(fdtb_pkg::QUO_W - 1)) begin
				cmd_q.depth <= neg_q ? 18'(-quo_ext) : quo_ext;
			end
		end
	end

endmodule

### design/fdtb_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on fdtb_pkg for the command struct.
module fdtb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fdtb_pkg::cmd_t din,
	input  logic           pop,
	output fdtb_pkg::cmd_t dout,
	output logic           full,
	output logic           empty
);

	fdtb_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

endmodule

### design/fdtb_back.sv
// Back part: carries out clears and fragments on the color and depth stores.
// Runs the depth test, one blend channel a cycle, and the output register.
// Depends on fdtb_pkg and fdtb_ram.
module fdtb_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fdtb_pkg::cfg_t               cfg,
	input  logic                         empty,
	input  fdtb_pkg::cmd_t               qcmd,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_passed,
	output logic [fdtb_pkg::CHAN_W-1:0]  out_r,
	output logic [fdtb_pkg::CHAN_W-1:0]  out_g,
	output logic [fdtb_pkg::CHAN_W-1:0]  out_b,
	output logic signed [fdtb_pkg::DEPTH_W-1:0] out_depth
);

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_RD    = 6'b000010,
		B_TEST  = 6'b000100,
		B_BLEND = 6'b001000,
		B_WR    = 6'b010000,
		B_CLR   = 6'b100000
	} bstate_t;

	bstate_t         state_q;
	fdtb_pkg::cmd_t  cur_q;
	logic [fdtb_pkg::COLOR_W-1:0] old_c_q;
	logic signed [fdtb_pkg::DEPTH_W-1:0] old_d_q;
	logic            pass_q;
	logic [1:0]      chan_q;
	logic [fdtb_pkg::CHAN_W-1:0] res_q [3];
	logic [fdtb_pkg::ADDR_W:0]   clr_q;
	logic            ovalid_q;

	logic [fdtb_pkg::ADDR_W:0]   npix;
	logic            c_we;
	logic            d_we;
	logic [fdtb_pkg::ADDR_W-1:0] waddr;
	logic [fdtb_pkg::COLOR_W-1:0] c_wdata;
	logic [fdtb_pkg::COLOR_W-1:0] c_rdata;
	logic [fdtb_pkg::DEPTH_W-1:0] d_rdata;
	logic [fdtb_pkg::CHAN_W-1:0] old_ch;
	logic [fdtb_pkg::CHAN_W-1:0] new_ch;
	logic [fdtb_pkg::CHAN_W:0]   sum;
	logic [25:0]     mix;
	logic [fdtb_pkg::CHAN_W-1:0] blend;
	logic [fdtb_pkg::COLOR_W-1:0] res_c;
	logic            clr_last;

	assign npix     = (fdtb_pkg::ADDR_W + 1)'(cfg.width * cfg.height);
	assign clr_last = (clr_q == npix - 1'b1);
	assign pop      = (state_q == B_IDLE) && !empty && !ovalid_q;
	assign out_valid = ovalid_q;
	assign res_c    = {res_q[2], res_q[1], res_q[0]};

	always_comb begin
		case (chan_q)
			2'd0: begin
				old_ch = old_c_q[11:0];
				new_ch = cur_q.r;
			end
			2'd1: begin
				old_ch = old_c_q[23:12];
				new_ch = cur_q.g;
			end
			default: begin
				old_ch = old_c_q[35:24];
				new_ch = cur_q.b;
			end
		endcase
		sum = {1'b0, old_ch} + {1'b0, new_ch};
		mix = 26'(old_ch * (fdtb_pkg::ALPHA_ONE - cur_q.a)) + 26'(new_ch * cur_q.a) + 26'd2048;
		case (cfg.blend_mode)
			fdtb_pkg::BM_REPLACE: blend = new_ch;
			fdtb_pkg::BM_ADD:     blend = sum[fdtb_pkg::CHAN_W] ? 12'hFFF : sum[11:0];
			fdtb_pkg::BM_ALPHA:   blend = (mix[25:24] != 2'b00) ? 12'hFFF : mix[23:12];
			default:              blend = old_ch;
		endcase
	end

	always_comb begin
		c_we    = 1'b0;
		d_we    = 1'b0;
		waddr   = cur_q.addr;
		c_wdata = res_c;
		if (state_q == B_CLR) begin
			c_we    = 1'b1;
			d_we    = 1'b1;
			waddr   = clr_q[fdtb_pkg::ADDR_W-1:0];
			c_wdata = {cur_q.b, cur_q.g, cur_q.r};
		end else if (state_q == B_WR) begin
			c_we = pass_q;
			d_we = pass_q && cfg.depth_write;
		end
	end

	fdtb_ram #(.WIDTH(fdtb_pkg::COLOR_W), .DEPTH(fdtb_pkg::STORE_SIZE)) u_color (
		.clk   (clk),
		.we    (c_we),
		.waddr (waddr),
		.wdata (c_wdata),
		.raddr (cur_q.addr),
		.rdata (c_rdata)
	);

	fdtb_ram #(.WIDTH(fdtb_pkg::DEPTH_W), .DEPTH(fdtb_pkg::STORE_SIZE)) u_depth (
		.clk   (clk),
		.we    (d_we),
		.waddr (waddr),
		.wdata (cur_q.depth),
		.raddr (cur_q.addr),
		.rdata (d_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						unique case (qcmd.kind)
							fdtb_pkg::K_CLEAR:  state_q <= B_CLR;
							fdtb_pkg::K_REJECT: ovalid_q <= 1'b1;
							default:            state_q <= B_RD;
						endcase
					end
				end
				B_RD:    state_q <= B_TEST;
				B_TEST:  state_q <= B_BLEND;
				B_BLEND: begin
					if (chan_q == 2'd2) begin
						state_q <= B_WR;
					end
				end
				B_WR: begin
					state_q  <= B_IDLE;
					ovalid_q <= 1'b1;
				end
				B_CLR: begin
					if (clr_last) begin
						state_q  <= B_IDLE;
						ovalid_q <= 1'b1;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= qcmd;
			clr_q <= '0;
			if (qcmd.kind == fdtb_pkg::K_REJECT) begin
				out_passed <= 1'b0;
				out_r      <= '0;
				out_g      <= '0;
				out_b      <= '0;
				out_depth  <= '0;
			end
		end
		if (state_q == B_TEST) begin
			old_c_q <= c_rdata;
			old_d_q <= d_rdata;
			pass_q  <= fdtb_pkg::depth_pass(cfg.depth_func, d_rdata, cur_q.depth);
			chan_q  <= 2'd0;
		end
		if (state_q == B_BLEND) begin
			res_q[chan_q] <= blend;
			chan_q        <= chan_q + 2'd1;
		end
		if (state_q == B_CLR) begin
			clr_q <= clr_q + 1'b1;
			if (clr_last) begin
				out_passed <= 1'b0;
				out_r      <= cur_q.r;
				out_g      <= cur_q.g;
				out_b      <= cur_q.b;
				out_depth  <= cur_q.depth;
			end
		end
		if (state_q == B_WR) begin
			out_passed <= pass_q;
			out_r      <= pass_q ? res_q[0] : old_c_q[11:0];
			out_g      <= pass_q ? res_q[1] : old_c_q[23:12];
			out_b      <= pass_q ? res_q[2] : old_c_q[35:24];
			out_depth  <= (pass_q && cfg.depth_write) ? cur_q.depth : old_d_q;
		end
	end

endmodule

### tb/sv/tb_fragment_depth_test_and_blend.sv
// Testbench for the fragment depth test and blend block, self-checking.
// Drives fragment and clear requests, predicts each result in a scoreboard
// class holding its own color and depth stores; depends on fdtb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_fragment_depth_test_and_blend;
	import fdtb_pkg::*;

	localparam int IDLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic                      passed;
		logic [CHAN_W-1:0]         r;
		logic [CHAN_W-1:0]         g;
		logic [CHAN_W-1:0]         b;
		logic signed [DEPTH_W-1:0] depth;
	} pixel_result_t;

	class raster_scoreboard;
		logic [COLOR_W-1:0]        color_mem [STORE_SIZE];
		logic signed [DEPTH_W-1:0] depth_mem [STORE_SIZE];
		int unsigned               width_eff = MAX_WIDTH;
		int unsigned               height_eff = MAX_HEIGHT;
		logic [2:0]                func = DF_LESS;
		logic                      zwrite = 1'b1;
		logic [1:0]                mode = BM_REPLACE;
		pixel_result_t             expected_q[$];
		int                        errors, n_frag, n_clear, n_pass, n_reject, n_checked;

		function int unsigned clamp_dim(logic [8:0] v, int unsigned maxv);
			if (v == 0)
				return 1;
			if (v > maxv)
				return maxv;
			return v;
		endfunction

		function logic signed [DEPTH_W-1:0] sat18(longint v);
			if (v > 131071)
				return DEPTH_MAX;
			if (v < -131072)
				return DEPTH_MIN;
			return v[DEPTH_W-1:0];
		endfunction

		function logic test_depth(logic signed [DEPTH_W-1:0] stored,
				logic signed [DEPTH_W-1:0] d);
			case (func)
				DF_ALWAYS:  return 1'b1;
				DF_LESS:    return d < stored;
				DF_LEQUAL:  return d <= stored;
				DF_GREATER: return d > stored;
				DF_GEQUAL:  return d >= stored;
				DF_EQUAL:   return d == stored;
				DF_NEQUAL:  return d != stored;
				default:    return 1'b0;
			endcase
		endfunction

		function void write_reg(logic [2:0] idx, logic [8:0] v);
			case (idx)
				CFG_FRAME_WIDTH:  width_eff = clamp_dim(v, MAX_WIDTH);
				CFG_FRAME_HEIGHT: height_eff = clamp_dim(v, MAX_HEIGHT);
				CFG_DEPTH_FUNC:   func = v[2:0];
				CFG_DEPTH_WRITE:  zwrite = v[0];
				CFG_BLEND_MODE:   mode = v[1:0];
				default: ;
			endcase
		endfunction

		function void note_request(logic op, logic [119:0] data);
			pixel_result_t res;
			int unsigned x, y, idx, a, k, old, nw, v;
			longint z, wv;
			logic signed [DEPTH_W-1:0] d;
			logic [COLOR_W-1:0] c, nc;
			x = data[7:0];
			y = data[15:8];
			z = $signed(data[39:16]);
			wv = $signed(data[63:40]);
			nc = data[99:64];
			a = data[112:100];
			res = '{1'b0, '0, '0, '0, '0};
			if (op == OP_CLEAR) begin
				n_clear++;
				d = sat18(z);
				for (int i = 0; i < width_eff * height_eff; i++) begin
					color_mem[i] = nc;
					depth_mem[i] = d;
				end
				res = '{1'b0, nc[11:0], nc[23:12], nc[35:24], d};
			end else if (x >= width_eff || y >= height_eff) begin
				n_reject++;
			end else begin
				n_frag++;
				idx = y * width_eff + x;
				d = (wv == 0) ? DEPTH_MAX : sat18((z * 65536) / wv);
				c = color_mem[idx];
				if (test_depth(depth_mem[idx], d)) begin
					n_pass++;
					if (zwrite)
						depth_mem[idx] = d;
					if (a > 4096)
						a = 4096;
					if (mode <= BM_ALPHA) begin
						for (k = 0; k < 3; k++) begin
							old = c[12*k +: 12];
							nw = nc[12*k +: 12];
							if (mode == BM_REPLACE)
								v = nw;
							else if (mode == BM_ADD)
								v = old + nw;
							else
								v = (old * (4096 - a) + nw * a + 2048) >> 12;
							c[12*k +: 12] = (v > 4095) ? 12'd4095 : v[11:0];
						end
						color_mem[idx] = c;
					end
					res.passed = 1'b1;
				end
				res.r = c[11:0];
				res.g = c[23:12];
				res.b = c[35:24];
				res.depth = depth_mem[idx];
			end
			expected_q.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(logic passed, logic [55:0] data);
			pixel_result_t e;
			if (expected_q.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			e = expected_q.pop_front();
			n_checked++;
			if (passed !== e.passed)
				report($sformatf("passed %b, predicted %b", passed, e.passed));
			if (data[11:0] !== e.r)
				report($sformatf("red %0d, predicted %0d", data[11:0], e.r));
			if (data[23:12] !== e.g)
				report($sformatf("green %0d, predicted %0d", data[23:12], e.g));
			if (data[35:24] !== e.b)
				report($sformatf("blue %0d, predicted %0d", data[35:24], e.b));
			if ($signed(data[53:36]) !== e.depth)
				report($sformatf("depth %0d, predicted %0d", $signed(data[53:36]), e.depth));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;
	logic         m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [8:0]   cfg_data = '0;

	raster_scoreboard sb = new();
	int  idle_cycles = 0;
	int  stall_style = 0;
	int  stall_cnt = 0;
	bit  hold_go = 0;
	bit  hold_on = 0;
	int  burst_left = 0;
	int  gap_max = 0;

	fragment_depth_test_and_blend dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("[fragment_depth_test_and_blend] ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			case (stall_style)
				0: m_tready <= !hold_on;
				1: m_tready <= !hold_on && ($urandom_range(0, 3) != 0);
				default: m_tready <= !hold_on && ((stall_cnt % 11) < 6);
			endcase
		end
	end

	initial begin
		forever begin
			wait (hold_go);
			hold_on = 1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on = 0;
			hold_go = 0;
		end
	end

	task automatic write_cfg(logic [2:0] idx, logic [8:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic send(logic op, logic [7:0] x, logic [7:0] y, logic [23:0] z,
			logic [23:0] w, logic [11:0] r, logic [11:0] g, logic [11:0] b, logic [12:0] a);
		logic [119:0] d;
		d = {7'd0, a, b, g, r, w, z, y, x};
		s_tdata <= d;
		s_tuser <= op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, d);
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end else
				burst_left--;
		end
	endtask

	task automatic frag(int x, int y, int z, int w, int r, int g, int b, int a);
		send(OP_FRAG, x, y, z, w, r, g, b, a);
	endtask

	task automatic random_request();
		int unsigned x, y, pick, wv, zv;
		pick = $urandom_range(0, 99);
		x = $urandom_range(0, (sb.width_eff + 1 > 255) ? 255 : sb.width_eff + 1);
		y = $urandom_range(0, (sb.height_eff + 1 > 255) ? 255 : sb.height_eff + 1);
		if (pick < 3)
			x = $urandom_range(0, 255);
		if (pick < 2 && sb.width_eff * sb.height_eff <= 4096) begin
			send(OP_CLEAR, x, y, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom());
			return;
		end
		if (pick < 15) begin
			zv = $urandom();
			wv = (pick < 6) ? 0 : $urandom();
		end else begin
			wv = 65536 + $urandom_range(0, 2) * 32768;
			zv = $urandom_range(0, 8) * 16384 - 65536;
			if (pick > 90)
				wv = -wv;
		end
		send(OP_FRAG, x, y, zv, wv, $urandom(), $urandom(), $urandom(),
			(pick % 5 == 0) ? $urandom() : $urandom_range(0, 4096));
	endtask

	function automatic logic [8:0] pick_dim(bit allow_full);
		case ($urandom_range(0, 9))
			0: return 9'd0;
			1: return allow_full ? 9'd511 : 9'd3;
			2: return allow_full ? 9'd256 : 9'd1;
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every pixel is written once so no later request reads an unwritten entry.
		send(OP_CLEAR, 0, 0, 0, 0, 12'h800, 12'h400, 12'h100, 0);
		frag(0, 0, -65536, 65536, 4095, 0, 4095, 0);
		frag(255, 255, 8388607, 1, 1, 2, 3, 4096);
		frag(254, 255, -8388608, 1, 0, 4095, 0, 8191);
		frag(17, 9, 100, 0, 7, 7, 7, 0);
		frag(18, 9, 65536, -65536, 4095, 4095, 4095, 4096);
		drain();

		write_cfg(CFG_FRAME_WIDTH, 9'd511);
		write_cfg(CFG_FRAME_HEIGHT, 9'd0);
		send(OP_CLEAR, 0, 0, 24'h7fffff, 0, 4095, 4095, 4095, 0);
		send(OP_CLEAR, 0, 0, 24'h800000, 0, 10, 20, 30, 0);
		frag(3, 1, 0, 65536, 1, 1, 1, 0);
		drain();
		write_cfg(CFG_FRAME_WIDTH, 9'd5);
		write_cfg(CFG_FRAME_HEIGHT, 9'd3);
		write_cfg(CFG_BLEND_MODE, BM_ADD);
		write_cfg(CFG_DEPTH_FUNC, DF_ALWAYS);
		write_cfg(CFG_DEPTH_WRITE, 1'b0);
		frag(5, 0, 0, 65536, 1, 1, 1, 0);
		frag(0, 3, 0, 65536, 1, 1, 1, 0);
		frag(4, 2, 0, 65536, 4095, 4000, 3000, 0);
		drain();
		write_cfg(CFG_BLEND_MODE, BM_ALPHA);
		frag(4, 2, 32768, 65536, 4095, 0, 2048, 8191);
		frag(4, 2, 32768, 65536, 0, 4095, 100, 0);
		frag(4, 2, 32768, 65536, 4095, 4095, 0, 2048);
		drain();
		write_cfg(CFG_BLEND_MODE, 2'd3);
		write_cfg(CFG_DEPTH_WRITE, 1'b1);
		frag(1, 1, 12345, 65536, 9, 9, 9, 0);
		drain();
		write_cfg(CFG_BLEND_MODE, BM_REPLACE);
		for (int f = 0; f < 8; f++) begin
			write_cfg(CFG_DEPTH_FUNC, f[2:0]);
			frag(1, 1, 12345 + (f % 3 - 1) * 4096, 65536, f, f, f, 0);
			drain();
		end

		for (int phase = 0; phase < 10; phase++) begin
			drain();
			write_cfg(CFG_FRAME_WIDTH, pick_dim(phase == 4));
			write_cfg(CFG_FRAME_HEIGHT, pick_dim(phase == 4));
			write_cfg(CFG_DEPTH_FUNC, $urandom_range(0, 7));
			write_cfg(CFG_DEPTH_WRITE, $urandom_range(0, 1));
			write_cfg(CFG_BLEND_MODE, $urandom_range(0, 3));
			stall_style = phase % 3;
			gap_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 8);
			if (phase == 3)
				hold_go = 1;
			for (int i = 0; i < 115; i++)
				random_request();
		end
		s_tvalid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d fragments (%0d passed), %0d rejected, %0d clears, %0d results",
			sb.n_frag, sb.n_pass, sb.n_reject, sb.n_clear, sb.n_checked);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("[fragment_depth_test_and_blend] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
			$display("[fragment_depth_test_and_blend] ERROR");
		end
		$finish;
	end

endmodule
